FILE: sv/multi_channel_pulse_width_capture_top_defines.svh
// ----------------------------------------------------------------------------
// Pulse width capture assertion macros
// Shared property shorthands for the capture block's checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH
`define MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse width capture check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse width capture check failed");

`endif

FILE: sv/pwc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width capture package
// Shared constants, codes and the request type passed along the cell chain.
// ----------------------------------------------------------------------------
package pwc_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF   = 4;
    localparam int WIDTH_BITS_DEF = 20;

    // Field widths.
    localparam int PIN_BITS      = 6;
    localparam int PIN_REG_BITS  = 7;
    localparam int TIME_BITS     = 32;
    localparam int DEADBAND_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int CELL_IDX_BITS = 3;

    // Channels that have a pin register; the others stay unassigned.
    localparam int PIN_REGS = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [PIN_REG_BITS-1:0]  UNASSIGNED_PIN = 7'd64;
    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 8'd6;

    // Request modes.
    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Event levels.
    localparam logic [1:0] LEVEL_FALL    = 2'd0;
    localparam logic [1:0] LEVEL_RISE    = 2'd1;
    localparam logic [1:0] LEVEL_TIMEOUT = 2'd2;
    localparam logic [1:0] LEVEL_IGNORE  = 2'd3;

    // Read status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_SIGNAL  = 2'd1;
    localparam logic [1:0] STATUS_UNASSIGNED = 2'd2;

    // One request as it travels from cell to cell.
    typedef struct packed {
        logic                 mode;
        logic [PIN_BITS-1:0]  event_pin;
        logic [1:0]           event_level;
        logic [TIME_BITS-1:0] event_time;
        logic [1:0]           read_channel;
    } pwc_req_t;

endpackage

FILE: sv/pwc_ifs.sv
// ----------------------------------------------------------------------------
// Pulse width capture channel interfaces
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------

// Request channel: edge events, timeouts and reads.
interface pwc_in_if;
    import pwc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [PIN_BITS-1:0]  event_pin;
    logic [1:0]           event_level;
    logic [TIME_BITS-1:0] event_time;
    logic [1:0]           read_channel;

    modport source (
        output valid, mode, event_pin, event_level, event_time, read_channel,
        input  ready
    );
    modport sink (
        input  valid, mode, event_pin, event_level, event_time, read_channel,
        output ready
    );
endinterface

// Result channel: one result for every request.
interface pwc_out_if #(
    parameter int WIDTH_BITS = pwc_pkg::WIDTH_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            read_status;
    logic [WIDTH_BITS-1:0] width_ticks;

    modport source (
        output valid, read_status, width_ticks,
        input  ready
    );
    modport sink (
        input  valid, read_status, width_ticks,
        output ready
    );
endinterface

FILE: sv/pwc_cell.sv
// ----------------------------------------------------------------------------
// Pulse width capture cell
// Holds one channel's capture state and applies each passing request to it.
// ----------------------------------------------------------------------------
module pwc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int WIDTH_BITS = pwc_pkg::WIDTH_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pwc_pkg::PIN_REG_BITS-1:0]    cfg_pin,
    input  logic [pwc_pkg::DEADBAND_BITS-1:0]   cfg_deadband,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pwc_pkg::pwc_req_t                   in_req,
    input  logic [1:0]                          in_status,
    input  logic [WIDTH_BITS-1:0]               in_width,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pwc_pkg::pwc_req_t                   out_req,
    output logic [1:0]                          out_status,
    output logic [WIDTH_BITS-1:0]               out_width
);
    import pwc_pkg::*;

    localparam logic [CELL_IDX_BITS-1:0] MY_INDEX = CELL_IDX_BITS'(CELL_INDEX);

    logic                  valid_reg;
    pwc_req_t              req_reg;
    logic [1:0]            status_reg, status_next;
    logic [WIDTH_BITS-1:0] width_reg, width_next;

    logic [TIME_BITS-1:0]  rise_time_reg, rise_time_next;
    logic [WIDTH_BITS-1:0] stored_width_reg, stored_width_next;
    logic                  width_valid_reg, width_valid_next;

    logic                  load;
    logic                  assigned;
    logic                  pin_hit;
    logic                  read_hit;
    logic [TIME_BITS-1:0]  span;
    logic [WIDTH_BITS-1:0] new_width;
    logic [WIDTH_BITS-1:0] width_diff;
    logic [WIDTH_BITS-1:0] deadband_wide;

    // The stage takes a request when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign assigned = !cfg_pin[PIN_REG_BITS-1];
    assign pin_hit  = assigned && (cfg_pin[PIN_BITS-1:0] == in_req.event_pin)
                      && (in_req.mode == MODE_EVENT);
    assign read_hit = (in_req.mode == MODE_READ)
                      && ({1'b0, in_req.read_channel} == MY_INDEX);

    // Width since the last rise, modulo 2^32, saturated to the result width.
    assign span          = in_req.event_time - rise_time_reg;
    assign new_width     = (|span[TIME_BITS-1:WIDTH_BITS]) ? '1 : span[WIDTH_BITS-1:0];
    assign width_diff    = (new_width > stored_width_reg) ? (new_width - stored_width_reg)
                                                          : (stored_width_reg - new_width);
    assign deadband_wide = {{(WIDTH_BITS-DEADBAND_BITS){1'b0}}, cfg_deadband};

    // Channel state update for a matching edge or timeout.
    always_comb
    begin
        rise_time_next    = rise_time_reg;
        stored_width_next = stored_width_reg;
        width_valid_next  = width_valid_reg;
        if (load && pin_hit)
        begin
            unique case (in_req.event_level)
                LEVEL_RISE:
                begin
                    rise_time_next = in_req.event_time;
                end
                LEVEL_FALL:
                begin
                    if (!width_valid_reg || (width_diff > deadband_wide))
                    begin
                        stored_width_next = new_width;
                        width_valid_next  = 1'b1;
                    end
                end
                LEVEL_TIMEOUT:
                begin
                    width_valid_next = 1'b0;
                end
                LEVEL_IGNORE:
                begin
                    width_valid_next = width_valid_reg;
                end
            endcase
        end
    end

    // Answer a read addressed to this channel; pass other results along.
    always_comb
    begin
        status_next = in_status;
        width_next  = in_width;
        if (read_hit)
        begin
            if (!assigned)
            begin
                status_next = STATUS_UNASSIGNED;
                width_next  = '0;
            end
            else if (!width_valid_reg)
            begin
                status_next = STATUS_NO_SIGNAL;
                width_next  = '0;
            end
            else
            begin
                status_next = STATUS_OK;
                width_next  = stored_width_reg;
            end
        end
    end

    // Channel state and stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            rise_time_reg    <= '0;
            stored_width_reg <= '0;
            width_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            rise_time_reg    <= rise_time_next;
            stored_width_reg <= stored_width_next;
            width_valid_reg  <= width_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg    <= in_req;
            status_reg <= status_next;
            width_reg  <= width_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_req    = req_reg;
    assign out_status = status_reg;
    assign out_width  = width_reg;

endmodule

FILE: sv/multi_channel_pulse_width_capture_top.sv
// ----------------------------------------------------------------------------
// Multi-channel pulse width capture
// Measures RC pulse widths on several channels with a chain of channel cells.
//
//   Channel   Direction   Carries
//   events    in          mode, event_pin, event_level, event_time, read_channel
//   results   out         read_status, width_ticks
//   cfg_*     in          pin per channel, change deadband
//
// One request is taken every cycle while the result channel is not stalled; each
// result passes one cell stage per channel, the last stage being the output.
// Reset clears all channel state and needs no clearing pass.
// A stalled result holds its stage; empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
module multi_channel_pulse_width_capture_top #(
    parameter int CHANNELS   = pwc_pkg::CHANNELS_DEF,
    parameter int WIDTH_BITS = pwc_pkg::WIDTH_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pwc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pwc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    pwc_in_if.sink                             events,
    pwc_out_if.source                          results
);
    import pwc_pkg::*;

`include "multi_channel_pulse_width_capture_top_defines.svh"

    logic [PIN_REG_BITS-1:0]  pin_reg [PIN_REGS];
    logic [DEADBAND_BITS-1:0] deadband_reg;

    logic [CHANNELS:0]     link_valid;
    logic [CHANNELS:0]     link_ready;
    pwc_req_t              link_req    [CHANNELS+1];
    logic [1:0]            link_status [CHANNELS+1];
    logic [WIDTH_BITS-1:0] link_width  [CHANNELS+1];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIN_REGS; i++)
            begin
                pin_reg[i] <= UNASSIGNED_PIN;
            end
            deadband_reg <= DEADBAND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DEADBAND)
            begin
                deadband_reg <= cfg_data;
            end
            else if (cfg_index < CFG_IDX_BITS'(PIN_REGS))
            begin
                pin_reg[cfg_index[1:0]] <= cfg_data[PIN_REG_BITS-1:0];
            end
        end
    end

    // Head of the chain: a read starts out as unassigned until its cell answers.
    assign link_valid[0]            = events.valid;
    assign events.ready             = link_ready[0];
    assign link_req[0].mode         = events.mode;
    assign link_req[0].event_pin    = events.event_pin;
    assign link_req[0].event_level  = events.event_level;
    assign link_req[0].event_time   = events.event_time;
    assign link_req[0].read_channel = events.read_channel;
    assign link_status[0] = (events.mode == MODE_READ) ? STATUS_UNASSIGNED : STATUS_OK;
    assign link_width[0]  = '0;

    // One cell per channel.
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_cell
        logic [PIN_REG_BITS-1:0] cell_pin;

        if (g < PIN_REGS)
        begin : g_pin
            assign cell_pin = pin_reg[g];
        end
        else
        begin : g_nopin
            assign cell_pin = UNASSIGNED_PIN;
        end

        pwc_cell #(
            .CELL_INDEX (g),
            .WIDTH_BITS (WIDTH_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg_pin      (cell_pin),
            .cfg_deadband (deadband_reg),
            .in_valid     (link_valid[g]),
            .in_ready     (link_ready[g]),
            .in_req       (link_req[g]),
            .in_status    (link_status[g]),
            .in_width     (link_width[g]),
            .out_valid    (link_valid[g+1]),
            .out_ready    (link_ready[g+1]),
            .out_req      (link_req[g+1]),
            .out_status   (link_status[g+1]),
            .out_width    (link_width[g+1])
        );
    end

    // Tail of the chain drives the result channel.
    assign results.valid       = link_valid[CHANNELS];
    assign link_ready[CHANNELS] = results.ready;
    assign results.read_status = link_status[CHANNELS];
    assign results.width_ticks = link_width[CHANNELS];

    // A status code outside the defined set never leaves the block.
    `PWC_ASSERT_SAME(a_status_code, results.valid, results.read_status <= STATUS_UNASSIGNED)

    // Only a valid width is ever shown.
    `PWC_ASSERT_SAME(a_width_zero,
        results.valid && (results.read_status != STATUS_OK), results.width_ticks == '0)

    // An accepted request always lands in the first cell stage.
    `PWC_ASSERT_NEXT(a_head_load, events.valid && events.ready, link_valid[1])

endmodule
